// ===== hdl/lsp_pkg.sv =====
`default_nettype none
package lsp_pkg;

  localparam int LSP_MAX_LABEL = 32;
  localparam int HDR_LEN       = 12;
  localparam int MIN_LINE      = 8;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_EOL  = 2'd1;
  localparam logic [1:0] CMD_EOI  = 2'd2;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_FOUND    = 2'd1;
  localparam logic [1:0] KIND_NOTFOUND = 2'd2;

  localparam logic [1:0] REG_PROCESS_LOCALS  = 2'd0;
  localparam logic [1:0] REG_LOCAL_JOIN_CHAR = 2'd1;
  localparam logic [1:0] REG_IGNORE_INTERNAL = 2'd2;

  localparam logic [3:0] CELL_LEAD     = 4'd0;
  localparam logic [3:0] CELL_LABEL    = 4'd1;
  localparam logic [3:0] CELL_COLON    = 4'd2;
  localparam logic [3:0] CELL_PRE_HEX  = 4'd3;
  localparam logic [3:0] CELL_HEX      = 4'd4;
  localparam logic [3:0] CELL_WANT_C   = 4'd5;
  localparam logic [3:0] CELL_COMPLETE = 4'd6;
  localparam logic [3:0] CELL_REJECT   = 4'd7;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  label_char;
    logic [31:0] symbol_offset;
    logic        last_char;
    logic        label_truncated;
  } out_item_t;

  typedef struct packed {
    logic take_byte;
    logic end_line;
    logic end_input;
    logic start_emit;
    logic load_char;
    logic clr_pending;
  } lsp_cmd_t;

  typedef struct packed {
    logic bar_emit;
    logic pend_emit;
    logic last_idx;
    logic out_free;
  } lsp_status_t;

  function automatic logic [7:0] hdr_char(input logic [3:0] pos, input logic upper);
    logic [7:0] ch;
    begin
      case (pos)
        4'd0: ch = upper ? "S" : "s";
        4'd1: ch = "y";
        4'd2: ch = "m";
        4'd3: ch = "b";
        4'd4: ch = "o";
        4'd5: ch = "l";
        4'd6: ch = " ";
        4'd7: ch = upper ? "T" : "t";
        4'd8: ch = "a";
        4'd9: ch = "b";
        4'd10: ch = "l";
        4'd11: ch = "e";
        default: ch = 8'd0;
      endcase
      return ch;
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = is_digit(c) ? (c - 8'd48) : (c - 8'd55);
      return v[3:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lsp_ram.sv =====
`default_nettype none
module lsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/lsp_ctrl.sv =====
`default_nettype none
module lsp_ctrl
  import lsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [1:0]  in_cmd,
  output logic             in_ready,
  input  wire lsp_status_t st,
  output lsp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_LD   = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_BYTE: begin
              if (st.pend_emit) begin
                cmd.start_emit = 1'b1;
                state_next     = S_RD;
              end else begin
                in_ready      = 1'b1;
                cmd.take_byte = 1'b1;
                if (st.bar_emit) begin
                  cmd.start_emit = 1'b1;
                  state_next     = S_RD;
                end
              end
            end
            CMD_EOL: begin
              in_ready     = 1'b1;
              cmd.end_line = 1'b1;
            end
            CMD_EOI: begin
              in_ready      = st.out_free;
              cmd.end_input = st.out_free;
            end
            default: begin
              in_ready = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        state_next = S_LD;
      end
      S_LD: begin
        if (st.out_free) begin
          cmd.load_char = 1'b1;
          if (st.last_idx) begin
            cmd.clr_pending = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/lsp_datapath.sv =====
`default_nettype none
module lsp_datapath
  import lsp_pkg::*;
#(
  parameter int MAX_LABEL = LSP_MAX_LABEL
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire in_item_t   in_item,
  input  wire lsp_cmd_t   cmd,
  output lsp_status_t     st,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item
);

  localparam int IDXW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int LENW = $clog2(MAX_LABEL + 1);
  localparam logic [LENW-1:0] MAX_LEN = LENW'(MAX_LABEL);
  localparam logic [3:0] LINE_FULL = 4'(MIN_LINE);
  localparam logic [3:0] HDR_END = 4'(HDR_LEN);

  logic            process_locals, ignore_internal;
  logic [7:0]      local_join_char;
  logic            table_found, table_found_next;
  logic            found_pending, found_pending_next;
  logic [3:0]      header_pos, header_pos_next;
  logic            header_lower_ok, header_lower_ok_next;
  logic            header_upper_ok, header_upper_ok_next;
  logic            hdr_started, hdr_started_next;
  logic [3:0]      cell_state, cell_state_next;
  logic [LENW-1:0] label_length, label_length_next;
  logic            label_overflow, label_overflow_next;
  logic [31:0]     offset_accum, offset_accum_next;
  logic [3:0]      line_count, line_count_next;
  logic [1:0]      lead_us, lead_us_next;
  logic [1:0]      seen, seen_next;
  logic            sym_pending, sym_pending_next;
  logic [IDXW-1:0] idx;

  logic            ram_we;
  logic [IDXW-1:0] ram_waddr;
  logic [7:0]      ram_rdata;

  logic [7:0] c;
  logic [3:0] lc_inc;
  logic       internal, label_ch, start_label, do_take, found_now;
  logic [LENW-1:0] len_base;
  logic [1:0] seen_base, lead_base;
  logic       ovf_base, lo_new, up_new;

  assign c        = in_item.text_byte;
  assign lc_inc   = (line_count < LINE_FULL) ? line_count + 4'd1 : line_count;
  assign internal = (seen == 2'd2) && (lead_us == 2'd2);
  assign label_ch = is_alpha(c) || is_digit(c) || (c == "_") ||
                    (process_locals && (c == local_join_char));
  assign found_now = table_found ||
                     (found_pending && (line_count >= LINE_FULL));

  assign st.bar_emit  = (in_item.command == CMD_BYTE) && table_found && (c == "|") &&
                        (cell_state == CELL_COMPLETE) && !(ignore_internal && internal) &&
                        (lc_inc >= LINE_FULL);
  assign st.pend_emit = (in_item.command == CMD_BYTE) && table_found && sym_pending &&
                        (lc_inc >= LINE_FULL);
  assign st.last_idx  = (LENW'(idx) + LENW'(1)) == label_length;
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_locals  <= 1'b1;
      local_join_char <= 8'd46;
      ignore_internal <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_LOCALS:  process_locals  <= cfg_data[0];
        REG_LOCAL_JOIN_CHAR: local_join_char <= cfg_data;
        REG_IGNORE_INTERNAL: ignore_internal <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    table_found_next     = table_found;
    found_pending_next   = found_pending;
    header_pos_next      = header_pos;
    header_lower_ok_next = header_lower_ok;
    header_upper_ok_next = header_upper_ok;
    hdr_started_next     = hdr_started;
    cell_state_next      = cell_state;
    label_length_next    = label_length;
    label_overflow_next  = label_overflow;
    offset_accum_next    = offset_accum;
    line_count_next      = line_count;
    lead_us_next         = lead_us;
    seen_next            = seen;
    sym_pending_next     = sym_pending;
    start_label          = 1'b0;
    do_take              = 1'b0;
    ram_we               = 1'b0;
    ram_waddr            = label_length[IDXW-1:0];
    lo_new               = header_lower_ok;
    up_new               = header_upper_ok;

    if (cmd.clr_pending) begin
      sym_pending_next = 1'b0;
    end

    if (cmd.take_byte) begin
      line_count_next = lc_inc;
      if (!table_found) begin
        if (hdr_started || !is_blank(c)) begin
          hdr_started_next = 1'b1;
          if (header_pos < HDR_END) begin
            lo_new = header_lower_ok && (c == hdr_char(header_pos, 1'b0));
            up_new = header_upper_ok && (c == hdr_char(header_pos, 1'b1));
            header_lower_ok_next = lo_new;
            header_upper_ok_next = up_new;
            header_pos_next      = header_pos + 4'd1;
            if ((header_pos + 4'd1 == HDR_END) && (lo_new || up_new)) begin
              found_pending_next = 1'b1;
            end
          end
        end
      end else if (c == "|") begin
        if ((cell_state == CELL_COMPLETE) && !(ignore_internal && internal) &&
            (lc_inc < LINE_FULL)) begin
          sym_pending_next = 1'b1;
        end
        cell_state_next = CELL_LEAD;
      end else begin
        case (cell_state)
          CELL_LEAD: begin
            if (!(is_blank(c) || (c == "*"))) begin
              if (is_alpha(c) || (c == "_")) begin
                start_label     = 1'b1;
                do_take         = 1'b1;
                cell_state_next = CELL_LABEL;
              end else begin
                cell_state_next = CELL_REJECT;
              end
            end
          end
          CELL_LABEL: begin
            if (label_ch) begin
              do_take = 1'b1;
            end else begin
              cell_state_next = (c == " ") ? CELL_COLON : CELL_REJECT;
            end
          end
          CELL_COLON: cell_state_next = (c == ":") ? CELL_PRE_HEX : CELL_REJECT;
          CELL_PRE_HEX: begin
            if (!is_blank(c)) begin
              if (is_hex(c)) begin
                offset_accum_next = {28'd0, hex_val(c)};
                cell_state_next   = CELL_HEX;
              end else begin
                cell_state_next = CELL_REJECT;
              end
            end
          end
          CELL_HEX: begin
            if (is_hex(c)) begin
              offset_accum_next = {offset_accum[27:0], hex_val(c)};
            end else begin
              cell_state_next = (c == " ") ? CELL_WANT_C : CELL_REJECT;
            end
          end
          CELL_WANT_C: cell_state_next = (c == "C") ? CELL_COMPLETE : CELL_REJECT;
          default: ;
        endcase
      end
    end

    len_base  = start_label ? '0 : label_length;
    seen_base = start_label ? 2'd0 : seen;
    lead_base = start_label ? 2'd0 : lead_us;
    ovf_base  = start_label ? 1'b0 : label_overflow;
    if (do_take) begin
      seen_next           = seen_base;
      lead_us_next        = lead_base;
      label_overflow_next = ovf_base;
      label_length_next   = len_base;
      if (seen_base < 2'd2) begin
        if ((seen_base == lead_base) && (c == "_")) begin
          lead_us_next = lead_base + 2'd1;
        end
        seen_next = seen_base + 2'd1;
      end
      if (len_base < MAX_LEN) begin
        ram_we            = 1'b1;
        ram_waddr         = len_base[IDXW-1:0];
        label_length_next = len_base + LENW'(1);
      end else begin
        label_overflow_next = 1'b1;
      end
    end

    if (cmd.end_line || cmd.end_input) begin
      if (cmd.end_line) begin
        table_found_next = found_now;
      end else begin
        table_found_next    = 1'b0;
        label_length_next   = '0;
        label_overflow_next = 1'b0;
        offset_accum_next   = '0;
        lead_us_next        = 2'd0;
        seen_next           = 2'd0;
      end
      found_pending_next   = 1'b0;
      header_pos_next      = 4'd0;
      header_lower_ok_next = 1'b1;
      header_upper_ok_next = 1'b1;
      hdr_started_next     = 1'b0;
      cell_state_next      = CELL_LEAD;
      sym_pending_next     = 1'b0;
      line_count_next      = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_found     <= 1'b0;
      found_pending   <= 1'b0;
      header_pos      <= 4'd0;
      header_lower_ok <= 1'b1;
      header_upper_ok <= 1'b1;
      hdr_started     <= 1'b0;
      cell_state      <= CELL_LEAD;
      label_length    <= '0;
      label_overflow  <= 1'b0;
      offset_accum    <= '0;
      line_count      <= 4'd0;
      lead_us         <= 2'd0;
      seen            <= 2'd0;
      sym_pending     <= 1'b0;
      idx             <= '0;
      out_valid       <= 1'b0;
    end else begin
      table_found     <= table_found_next;
      found_pending   <= found_pending_next;
      header_pos      <= header_pos_next;
      header_lower_ok <= header_lower_ok_next;
      header_upper_ok <= header_upper_ok_next;
      hdr_started     <= hdr_started_next;
      cell_state      <= cell_state_next;
      label_length    <= label_length_next;
      label_overflow  <= label_overflow_next;
      offset_accum    <= offset_accum_next;
      line_count      <= line_count_next;
      lead_us         <= lead_us_next;
      seen            <= seen_next;
      sym_pending     <= sym_pending_next;
      if (cmd.start_emit) begin
        idx <= '0;
      end else if (cmd.load_char) begin
        idx <= idx + IDXW'(1);
      end
      if (cmd.load_char || cmd.end_input) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      out_item.result_kind     <= KIND_CHAR;
      out_item.label_char      <= ram_rdata;
      out_item.symbol_offset   <= offset_accum;
      out_item.last_char       <= st.last_idx;
      out_item.label_truncated <= label_overflow;
    end else if (cmd.end_input) begin
      out_item.result_kind     <= found_now ? KIND_FOUND : KIND_NOTFOUND;
      out_item.label_char      <= 8'd0;
      out_item.symbol_offset   <= 32'd0;
      out_item.last_char       <= 1'b0;
      out_item.label_truncated <= 1'b0;
    end
  end

  lsp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (c),
    .raddr (idx),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== hdl/listing_symbol_table_parser_core.sv =====
// Symbol table extractor for an assembler listing.
// The input channel (in_valid, in_ready, in_item) carries one text byte, an
// end-of-line marker or an end-of-input marker per transfer. The output
// channel (out_valid, out_ready, out_item) carries one label character per
// transfer, or the final status once end of input has been taken.
// A text byte, end of line or end of input is taken when no
// label is being streamed; end of input also waits until the output
// register is free. A label is read back from the label RAM one
// character at a time: each character passes a RAM read state and then
// an output register load state, which waits while the output register
// is busy, and the input is held until the whole label has been streamed.
// Results leave through a single output register; when the receiver stalls
// the register holds its transfer and the streaming simply waits.
// A synchronous reset returns the parser to searching for the header and
// sets the configuration registers to their defaults; the label RAM is not
// cleared, as it is only read below the stored label length.
`default_nettype none
module listing_symbol_table_parser_core
  import lsp_pkg::*;
#(
  parameter int MAX_LABEL = LSP_MAX_LABEL
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item
);

  lsp_cmd_t    cmd;
  lsp_status_t st;

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_item.command),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lsp_datapath #(
    .MAX_LABEL (MAX_LABEL)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== hdl/lsp_checker.sv =====
`default_nettype none
module lsp_checker
  import lsp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Output transfer changed while stalled.");

  a_final_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_item.command == CMD_EOI) |=>
      out_valid && ((out_item.result_kind == KIND_FOUND) ||
                    (out_item.result_kind == KIND_NOTFOUND)))
    else $error("End of input did not yield a status result.");

  a_final_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.result_kind != KIND_CHAR) |->
      (out_item.label_char == 8'd0) && (out_item.symbol_offset == 32'd0) &&
      !out_item.last_char && !out_item.label_truncated)
    else $error("Status result carries label data.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind listing_symbol_table_parser_core lsp_checker u_lsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
